[src/aes_pkg.sv]
// shared types, constants and s-box tables for the block cipher core
// no dependencies
package aes_pkg;

   localparam int BLOCK_W = 128;
   localparam int KEY_W = 256;
   localparam int ROWS = 15;
   localparam int ROW_AW = 4;
   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;

   // key size codes
   localparam logic [1:0] KEY_SIZE_128 = 2'd0;
   localparam logic [1:0] KEY_SIZE_192 = 2'd1;
   localparam logic [1:0] KEY_SIZE_256 = 2'd2;

   // register indexes
   localparam logic [2:0] REG_KEY0 = 3'd0;
   localparam logic [2:0] REG_KEY1 = 3'd1;
   localparam logic [2:0] REG_KEY2 = 3'd2;
   localparam logic [2:0] REG_KEY3 = 3'd3;
   localparam logic [2:0] REG_KSIZE = 3'd4;

   typedef struct packed {
      logic [63:0] block_first;
      logic [63:0] block_second;
      logic        mode;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] result_first;
      logic [63:0] result_second;
   } rsp_payload_type;

   // round unit control
   typedef struct packed {
      logic dec;
      logic key_only;
      logic last;
   } round_ctl_type;

   // key schedule write side
   typedef struct packed {
      logic              wr_en;
      logic [ROW_AW-1:0] wr_addr;
      logic              done;
   } kexp_status_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] sub_byte(input logic [7:0] x);
      return SBOX[x];
   endfunction

   function automatic logic [7:0] inv_sub_byte(input logic [7:0] x);
      return INV_SBOX[x];
   endfunction

   // key words per key size code: 4, 6 or 8 (code three acts as 256 bit)
   function automatic logic [3:0] key_words(input logic [1:0] code);
      logic [3:0] nk;
      case (code)
         KEY_SIZE_128: nk = 4'd4;
         KEY_SIZE_192: nk = 4'd6;
         default:      nk = 4'd8;
      endcase
      return nk;
   endfunction

endpackage

[src/aes_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module aes_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/aes_key_exp.sv]
// key schedule: one key word per cycle while run, written to key ram a row at a time
// depends on aes_pkg
module aes_key_exp import aes_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  run,
   input  logic [KEY_W-1:0]      key,
   input  logic [1:0]            key_size,
   output kexp_status_type       status,
   output logic [BLOCK_W-1:0]    wr_data
);

   logic [5:0]  idx_ff, idx_in;
   logic [2:0]  modnk_ff, modnk_in;
   logic [7:0]  rc_ff, rc_in;
   logic [31:0] win_ff [8];
   logic [95:0] acc_ff;
   logic [3:0]  nk;
   logic [5:0]  last_idx;
   logic [31:0] prev, back, tmp, word;

   assign nk = key_words(key_size);
   assign last_idx = 6'(({2'b00, nk} + 6'd7) * 6'd4 - 6'd1);

   // word nk back in the window
   always_comb begin
      case (nk)
         4'd4:    back = win_ff[3];
         4'd6:    back = win_ff[5];
         default: back = win_ff[7];
      endcase
   end

   // next schedule word
   always_comb begin
      prev = win_ff[0];
      tmp = prev;
      if (modnk_ff == 3'd0) begin
         tmp = {sub_byte(prev[23:16]), sub_byte(prev[15:8]), sub_byte(prev[7:0]),
                sub_byte(prev[31:24])} ^ {rc_ff, 24'd0};
      end else if (nk == 4'd8 && modnk_ff == 3'd4) begin
         tmp = {sub_byte(prev[31:24]), sub_byte(prev[23:16]), sub_byte(prev[15:8]),
                sub_byte(prev[7:0])};
      end
      if (idx_ff < {2'b00, nk}) begin
         word = key[KEY_W - 1 - 32 * int'(idx_ff[2:0]) -: 32];
      end else begin
         word = back ^ tmp;
      end
   end

   // counters
   always_comb begin
      idx_in = idx_ff;
      modnk_in = modnk_ff;
      rc_in = rc_ff;
      if (start) begin
         idx_in = 6'd0;
         modnk_in = 3'd0;
         rc_in = 8'h01;
      end else if (run) begin
         idx_in = idx_ff + 6'd1;
         modnk_in = ({1'b0, modnk_ff} == nk - 4'd1) ? 3'd0 : modnk_ff + 3'd1;
         if (modnk_ff == 3'd0 && idx_ff >= {2'b00, nk}) begin
            rc_in = {rc_ff[6:0], 1'b0} ^ (rc_ff[7] ? 8'h1b : 8'h00);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         modnk_ff <= '0;
         rc_ff <= 8'h01;
      end else begin
         idx_ff <= idx_in;
         modnk_ff <= modnk_in;
         rc_ff <= rc_in;
      end
   end

   // sliding window and row accumulator
   always_ff @(posedge clock) begin
      if (run && !start) begin
         win_ff[0] <= word;
         for (int j = 1; j < 8; j++) begin
            win_ff[j] <= win_ff[j-1];
         end
         acc_ff <= {acc_ff[63:0], word};
      end
   end

   assign wr_data = {acc_ff, word};
   assign status.wr_en = run && !start && idx_ff[1:0] == 2'd3;
   assign status.wr_addr = idx_ff[5:2];
   assign status.done = run && !start && idx_ff == last_idx;

endmodule

[src/aes_round.sv]
// shared round unit: one cipher/inverse round or key add per use
// depends on aes_pkg
module aes_round import aes_pkg::*; (
   input  logic [BLOCK_W-1:0] state,
   input  logic [BLOCK_W-1:0] round_key,
   input  round_ctl_type      ctl,
   output logic [BLOCK_W-1:0] result
);

   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   logic [7:0] s [16];
   logic [7:0] a [16];
   logic [7:0] b [16];
   logic [7:0] m [16];
   logic [7:0] k [16];
   logic [7:0] c0, c1, c2, c3, x2, x4, x8;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         s[i] = state[BLOCK_W - 1 - 8 * i -: 8];
         k[i] = round_key[BLOCK_W - 1 - 8 * i -: 8];
      end
      // substitution and row shift, in cipher or inverse order
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (ctl.dec) begin
               a[r + 4 * ((c + r) % 4)] = inv_sub_byte(s[r + 4 * c]);
            end else begin
               a[r + 4 * c] = sub_byte(s[r + 4 * ((c + r) % 4)]);
            end
         end
      end
      // inverse cipher adds the key before mixing
      for (int i = 0; i < 16; i++) begin
         b[i] = ctl.dec ? (a[i] ^ k[i]) : a[i];
      end
      // column mixing
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            c0 = b[4 * c + r];
            c1 = b[4 * c + (r + 1) % 4];
            c2 = b[4 * c + (r + 2) % 4];
            c3 = b[4 * c + (r + 3) % 4];
            if (ctl.dec) begin
               // 14, 11, 13, 9 from the x2/x4/x8 multiples
               x2 = xt(c0 ^ c1);
               x4 = xt(xt(c0 ^ c2));
               x8 = xt(xt(xt(c0 ^ c1 ^ c2 ^ c3)));
               m[4 * c + r] = x8 ^ x4 ^ x2 ^ c1 ^ c2 ^ c3;
            end else begin
               x2 = xt(c0);
               x4 = xt(c1);
               x8 = 8'h00;
               m[4 * c + r] = x2 ^ x4 ^ c1 ^ c2 ^ c3 ^ x8;
            end
         end
      end
      for (int i = 0; i < 16; i++) begin
         if (ctl.key_only) begin
            result[BLOCK_W - 1 - 8 * i -: 8] = s[i] ^ k[i];
         end else if (ctl.dec) begin
            result[BLOCK_W - 1 - 8 * i -: 8] = ctl.last ? b[i] : m[i];
         end else begin
            result[BLOCK_W - 1 - 8 * i -: 8] = (ctl.last ? a[i] : m[i]) ^ k[i];
         end
      end
   end

endmodule

[src/aes_block_cipher.sv]
// top level of the block cipher core: register port, sequencer, key ram
// depends on aes_pkg, aes_ram, aes_key_exp, aes_round
//
// usage
//  - the register port holds the key in four 64-bit registers and the key
//    size code; a write to any of these marks the round keys stale
//  - one request transaction carries a 128-bit block and a mode bit
//    (0 encrypt, 1 decrypt); one response transaction returns the result
//  - req_ready is high only while the core is idle; an accepted block then
//    goes through one key ram read setup, nr + 1 passes of the shared round
//    unit (nr = 10, 12 or 14) and a move of the result to the output
//    register, which raises rsp_valid
//  - the first block after a key write first runs the key schedule, one
//    word a cycle: 44, 52 or 60 words
//  - a new block is taken only after the last one is finished, since every
//    round goes through the single round unit
//  - reset clears all control state and sets the key size to 256 bit; the
//    round keys are rebuilt on the first block
//  - while the receiver stalls the result is held in the output register
//    and a finished block waits in the core, which takes no new transaction
module aes_block_cipher import aes_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_payload_type     req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_payload_type     rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXPAND = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_ROUND  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [63:0]        key_ff [4];
   logic [1:0]         ksize_ff;
   logic               sched_ok_ff, sched_ok_in;
   logic [BLOCK_W-1:0] blk_ff, blk_in;
   logic               dec_ff, dec_in;
   logic [3:0]         rnd_ff, rnd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0] rsp_blk_ff;
   logic               csr_wr;
   logic [2:0]         csr_idx;
   logic [3:0]         nr, cur, row_sel;
   logic [ROW_AW-1:0]  rd_addr;
   logic [BLOCK_W-1:0] rk_row, rk_wdata, rnd_out;
   kexp_status_type    kx;
   round_ctl_type      rctl;
   logic               accept, out_free, exp_start;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = csr_paddr[5:3];

   always_comb begin
      case (csr_idx)
         REG_KEY0:  csr_prdata = key_ff[0];
         REG_KEY1:  csr_prdata = key_ff[1];
         REG_KEY2:  csr_prdata = key_ff[2];
         REG_KEY3:  csr_prdata = key_ff[3];
         REG_KSIZE: csr_prdata = {62'd0, ksize_ff};
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 4; j++) begin
            key_ff[j] <= '0;
         end
         ksize_ff <= KEY_SIZE_256;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_KEY0:  key_ff[0] <= csr_pwdata;
            REG_KEY1:  key_ff[1] <= csr_pwdata;
            REG_KEY2:  key_ff[2] <= csr_pwdata;
            REG_KEY3:  key_ff[3] <= csr_pwdata;
            REG_KSIZE: ksize_ff <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   assign nr = key_words(ksize_ff) + 4'd6;
   assign cur = rnd_ff - 4'd1;

   // key schedule
   assign exp_start = accept && !sched_ok_ff;

   aes_key_exp u_key_exp (
      .clock    (clock),
      .reset    (reset),
      .start    (exp_start),
      .run      (state_ff == ST_EXPAND),
      .key      ({key_ff[0], key_ff[1], key_ff[2], key_ff[3]}),
      .key_size (ksize_ff),
      .status   (kx),
      .wr_data  (rk_wdata)
   );

   // round key row for the next round, reversed when decrypting
   assign row_sel = (rnd_ff > nr) ? 4'd0 : (dec_ff ? nr - rnd_ff : rnd_ff);
   assign rd_addr = row_sel;

   aes_ram #(
      .WIDTH (BLOCK_W),
      .DEPTH (ROWS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (kx.wr_en),
      .wr_addr (kx.wr_addr),
      .wr_data (rk_wdata),
      .rd_addr (rd_addr),
      .rd_data (rk_row)
   );

   // shared round unit
   assign rctl.dec = dec_ff;
   assign rctl.key_only = (cur == 4'd0);
   assign rctl.last = (cur == nr);

   aes_round u_round (
      .state     (blk_ff),
      .round_key (rk_row),
      .ctl       (rctl),
      .result    (rnd_out)
   );

   // sequencer
   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      sched_ok_in = sched_ok_ff;
      blk_in = blk_ff;
      dec_in = dec_ff;
      rnd_in = rnd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               blk_in = {req_data.block_first, req_data.block_second};
               dec_in = req_data.mode;
               rnd_in = 4'd0;
               state_in = sched_ok_ff ? ST_LOAD : ST_EXPAND;
            end
         end
         ST_EXPAND: begin
            if (kx.done) begin
               sched_ok_in = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            rnd_in = rnd_ff + 4'd1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            blk_in = rnd_out;
            rnd_in = rnd_ff + 4'd1;
            if (cur == nr) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_wr && csr_idx <= REG_KSIZE) begin
         sched_ok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sched_ok_ff <= 1'b0;
         rnd_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sched_ok_ff <= sched_ok_in;
         rnd_ff <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working block and output register
   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      dec_ff <= dec_in;
      if (state_ff == ST_FINISH && out_free) begin
         rsp_blk_ff <= blk_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.result_first = rsp_blk_ff[127:64];
   assign rsp_data.result_second = rsp_blk_ff[63:0];

endmodule

[verif/tb_top.sv]
// testbench for the aes block cipher core: encrypt/decrypt transactions checked
// against a behavioral cipher with its own key schedule; depends on aes_pkg and the rtl
`timescale 1ns / 1ps
module tb_top import aes_pkg::*; ();

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_payload_type     req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_payload_type     rsp_data;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   aes_block_cipher u_top (.*);

   localparam int CYCLE_LIMIT = 900000;
   localparam logic [1:0] KEY_SIZE_CODE3 = 2'd3;
   localparam logic [7:0] RCON [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                        8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   // predictor state
   logic [63:0]      key_reg [4];
   logic [1:0]       ksize;
   logic [31:0]      rkey [60];
   logic [7:0]       sb [256];
   logic [7:0]       isb [256];

   req_payload_type  block_q [$];
   rsp_payload_type  cipher_q [$];
   int               errors;
   int               cycles;
   int               n_enc, n_dec, n_cfg;
   bit               hold_rsp;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // gf(2^8) helpers
   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gm(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r ^= a;
         a = xt(a);
      end
      return r;
   endfunction

   // s-box tables from the field inverse and the affine map
   task automatic build_sbox();
      logic [7:0] inv, s;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h01;
         for (int e = 0; e < 254; e++) inv = gm(inv, x[7:0]);
         if (x == 0) inv = 8'h00;
         s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         sb[x] = s;
         isb[s] = x[7:0];
      end
   endtask

   function automatic int nk_of(input logic [1:0] c);
      return (c == KEY_SIZE_128) ? 4 : (c == KEY_SIZE_192) ? 6 : 8;
   endfunction

   function automatic logic [31:0] subw(input logic [31:0] w);
      return {sb[w[31:24]], sb[w[23:16]], sb[w[15:8]], sb[w[7:0]]};
   endfunction

   // standard key schedule
   task automatic expand_schedule();
      int nk;
      logic [31:0] t;
      nk = nk_of(ksize);
      for (int i = 0; i < nk; i++)
         rkey[i] = (i % 2 == 0) ? key_reg[i / 2][63:32] : key_reg[i / 2][31:0];
      for (int i = nk; i < 4 * (nk + 7) && i < 60; i++) begin
         t = rkey[i - 1];
         if (i % nk == 0) t = subw({t[23:0], t[31:24]}) ^ {RCON[(i / nk - 1) % 10], 24'h0};
         else if (nk > 6 && i % nk == 4) t = subw(t);
         rkey[i] = rkey[i - nk] ^ t;
      end
   endtask

   function automatic void add_rk(inout logic [7:0] s [16], input int r);
      for (int c = 0; c < 4; c++)
         for (int b = 0; b < 4; b++) s[4*c+b] ^= rkey[r*4+c][31-8*b -: 8];
   endfunction

   function automatic void shift_st(inout logic [7:0] s [16], input bit inv);
      logic [7:0] t [16];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            if (inv) t[r + 4*((c+r)%4)] = s[r + 4*c];
            else t[r + 4*c] = s[r + 4*((c+r)%4)];
      s = t;
   endfunction

   function automatic void mix_st(inout logic [7:0] s [16], input bit inv);
      logic [7:0] m [4];
      logic [7:0] col [4];
      if (inv) begin
         m[0] = 8'd14; m[1] = 8'd11; m[2] = 8'd13; m[3] = 8'd9;
      end else begin
         m[0] = 8'd2; m[1] = 8'd3; m[2] = 8'd1; m[3] = 8'd1;
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) col[r] = s[4*c+r];
         for (int r = 0; r < 4; r++)
            s[4*c+r] = gm(col[r], m[0]) ^ gm(col[(r+1)%4], m[1])
                     ^ gm(col[(r+2)%4], m[2]) ^ gm(col[(r+3)%4], m[3]);
      end
   endfunction

   function automatic rsp_payload_type cipher_block(input req_payload_type p);
      logic [7:0] s [16];
      int nr;
      rsp_payload_type o;
      nr = nk_of(ksize) + 6;
      for (int i = 0; i < 8; i++) begin
         s[i] = p.block_first[63-8*i -: 8];
         s[8+i] = p.block_second[63-8*i -: 8];
      end
      if (!p.mode) begin
         add_rk(s, 0);
         for (int r = 1; r <= nr; r++) begin
            for (int i = 0; i < 16; i++) s[i] = sb[s[i]];
            shift_st(s, 1'b0);
            if (r < nr) mix_st(s, 1'b0);
            add_rk(s, r);
         end
      end else begin
         add_rk(s, nr);
         for (int r = nr - 1; r >= 0; r--) begin
            shift_st(s, 1'b1);
            for (int i = 0; i < 16; i++) s[i] = isb[s[i]];
            add_rk(s, r);
            if (r > 0) mix_st(s, 1'b1);
         end
      end
      for (int i = 0; i < 8; i++) begin
         o.result_first[63-8*i -: 8] = s[i];
         o.result_second[63-8*i -: 8] = s[8+i];
      end
      return o;
   endfunction

   // register write, setup then access phase on the bus
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(idx) << 3;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_KSIZE) ksize = val[1:0];
      else key_reg[idx] = val;
      n_cfg++;
   endtask

   task automatic wait_idle();
      while (block_q.size() != 0 || cipher_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // append one pending transaction for the driver
   task automatic queue_block(input req_payload_type p);
      block_q.insert(block_q.size(), p);
   endtask

   function automatic logic [63:0] rnd64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic load_key(input logic [1:0] code, input bit extreme);
      for (int i = 0; i < 4; i++) begin
         logic [63:0] v;
         v = extreme ? (($urandom_range(0, 1) == 1) ? '1 : '0) : rnd64();
         csr_write(3'(i), v);
      end
      csr_write(REG_KSIZE, {62'd0, code});
      expand_schedule();
   endtask

   function automatic req_payload_type mk_block(input logic [63:0] a, input logic [63:0] b,
                                                input logic m);
      req_payload_type p;
      p.block_first = a;
      p.block_second = b;
      p.mode = m;
      return p;
   endfunction

   // stimulus
   initial begin
      logic [1:0] codes [6];
      errors = 0;
      n_enc = 0; n_dec = 0; n_cfg = 0;
      hold_rsp = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      ksize = KEY_SIZE_256;
      build_sbox();
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset key, then known vectors and field extremes
      expand_schedule();
      queue_block(mk_block('0, '0, 1'b0));
      queue_block(mk_block('1, '1, 1'b1));
      wait_idle();
      csr_write(REG_KEY0, 64'h0001020304050607);
      csr_write(REG_KEY1, 64'h08090a0b0c0d0e0f);
      csr_write(REG_KSIZE, {62'd0, KEY_SIZE_128});
      expand_schedule();
      queue_block(mk_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0));
      queue_block(mk_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1));
      queue_block(mk_block('1, '0, 1'b0));
      queue_block(mk_block('0, '1, 1'b1));
      wait_idle();
      // key size code three runs as a 256-bit key
      csr_write(REG_KEY2, 64'h1011121314151617);
      csr_write(REG_KEY3, 64'h18191a1b1c1d1e1f);
      csr_write(REG_KSIZE, {62'd0, KEY_SIZE_CODE3});
      expand_schedule();
      queue_block(mk_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0));
      queue_block(mk_block(64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1));
      wait_idle();
      // unused key words changed under a short key are ignored
      load_key(KEY_SIZE_192, 1'b1);
      queue_block(mk_block(rnd64(), rnd64(), 1'b0));
      queue_block(mk_block(rnd64(), rnd64(), 1'b1));
      wait_idle();
      csr_write(REG_KEY3, rnd64());
      expand_schedule();
      queue_block(mk_block(rnd64(), rnd64(), 1'b0));
      wait_idle();

      // random phases over key sizes, extremes included
      codes = '{KEY_SIZE_128, KEY_SIZE_192, KEY_SIZE_256, KEY_SIZE_CODE3,
                KEY_SIZE_128, KEY_SIZE_256};
      for (int ph = 0; ph < 14; ph++) begin
         load_key(codes[ph % 6], ph == 3 || ph == 9);
         if (ph == 5) hold_rsp = 1'b1;
         for (int k = 0; k < 100; k++)
            queue_block(mk_block(rnd64(), rnd64(), 1'($urandom_range(0, 1))));
         wait_idle();
      end

      repeat (50) @(posedge clock);
      $display("covered %0d encrypt and %0d decrypt blocks over %0d register writes",
               n_enc, n_dec, n_cfg);
      $display("key sizes 128/192/256 and code three, with random stalls on both sides");
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // driver
   int src_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         src_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            cipher_q.insert(cipher_q.size(), cipher_block(req_data));
            if (req_data.mode) n_dec++; else n_enc++;
            void'(block_q.pop_front());
         end
         if (req_valid && !req_ready) begin
            // hold the transaction
         end else if (src_gap > 0) begin
            req_valid <= 1'b0;
            src_gap <= src_gap - 1;
         end else if (block_q.size() != 0) begin
            req_valid <= 1'b1;
            req_data <= block_q[0];
            src_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and receiver stalls
   int sink_gap;
   int long_hold;
   rsp_payload_type exp_c;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         sink_gap <= 0;
         long_hold <= 0;
         cycles <= 0;
      end else begin
         cycles <= cycles + 1;
         if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (cipher_q.size() == 0) begin
               $error("unexpected response %h", rsp_data);
               errors++;
            end else begin
               exp_c = cipher_q.pop_front();
               if (rsp_data.result_first !== exp_c.result_first) begin
                  $error("result_first expected %h actual %h",
                         exp_c.result_first, rsp_data.result_first);
                  errors++;
               end
               if (rsp_data.result_second !== exp_c.result_second) begin
                  $error("result_second expected %h actual %h",
                         exp_c.result_second, rsp_data.result_second);
                  errors++;
               end
            end
         end
         if (hold_rsp && long_hold == 0) begin
            // one long hold-off so the core fills and stalls its input
            hold_rsp = 1'b0;
            long_hold <= 400;
            rsp_ready <= 1'b0;
         end else if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            rsp_ready <= 1'b0;
         end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_valid && rsp_ready)
               sink_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         end
      end
   end

   // idle values before the first clock edge
   initial begin
      clock = 1'b0;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
   end

endmodule

[files.f]
src/aes_pkg.sv
src/aes_ram.sv
src/aes_key_exp.sv
src/aes_round.sv
src/aes_block_cipher.sv
verif/tb_top.sv
